[rtl/mrrq_pkg.sv]
`default_nettype none

package mrrq_pkg;

    // Default sizes of the scheduler.
    localparam int LEVELS_DEF      = 3;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int PID_BITS_DEF    = 8;

    // Depth of the command queue between the front and the back.
    localparam int WQ_DEPTH = 2;

    // Payload widths of the two channels.
    localparam int CMD_W    = 2;
    localparam int PID_W    = 8;
    localparam int PRIO_W   = 2;
    localparam int STATUS_W = 3;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;

    // Highest priority that an insert may ever name.
    localparam logic [PRIO_W-1:0] MAX_PRIORITY = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_PRIORITY = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_REMOVE_ZERO  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_ALL_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL         = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [PID_W-1:0]  pid;
        logic [PRIO_W-1:0] priority_req;
    } cmd_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PID_W-1:0]    running_pid;
        logic                running_valid;
    } rsp_item_t;

    // Operation after classification by the front.
    typedef enum logic [2:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_TIMEOUT,
        OP_CLEAR,
        OP_REPORT
    } op_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        op_t                 op;
        logic [PID_W-1:0]    pid;
        logic [PRIO_W-1:0]   level;
        logic [STATUS_W-1:0] status;
    } work_t;

    // Sequencer states of the back.
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RM_RD,
        S_RM_CMP,
        S_SH_RD,
        S_SH_WR,
        S_TO_WR,
        S_HEAD_RD,
        S_HEAD_OUT
    } state_t;

endpackage

`default_nettype wire

[rtl/multilevel_round_robin_ready_queue.sv]
// Insert, clear, timeout and rejected commands run straight through the back
// sequencer to the result; a remove takes longer, set by the search and
// compaction on the pid RAM, which read and then compare or move one entry at a time.
// Throughput: one command at a time in the back sequencer; a two-entry command
// queue keeps accepting transfers while it works. Reset is asynchronous, active
// low, and empties all levels at once; the pid RAM needs no clearing.
`default_nettype none

module multilevel_round_robin_ready_queue
    import mrrq_pkg::*;
#(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int PID_BITS    = PID_BITS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire cmd_item_t cmd_data,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_item_t      rsp_data
);

    logic  work_valid;
    logic  work_pop;
    work_t work_head;

    mrrq_front #(
        .LEVELS   (LEVELS),
        .PID_BITS (PID_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_data   (cmd_data),
        .work_valid (work_valid),
        .work_pop   (work_pop),
        .work_head  (work_head)
    );

    mrrq_back #(
        .LEVELS      (LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PID_BITS    (PID_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (work_valid),
        .work_pop   (work_pop),
        .work_head  (work_head),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data)
    );

endmodule

`default_nettype wire

[rtl/mrrq_ram.sv]
`default_nettype none

module mrrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/mrrq_front.sv]
`default_nettype none

module mrrq_front
    import mrrq_pkg::*;
#(
    parameter int LEVELS   = LEVELS_DEF,
    parameter int PID_BITS = PID_BITS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire cmd_item_t cmd_data,
    output logic           work_valid,
    input  wire logic      work_pop,
    output work_t          work_head
);

    localparam int PTR_W = $clog2(WQ_DEPTH);
    localparam int CNT_W = $clog2(WQ_DEPTH + 1);
    localparam logic [PID_W-1:0] PID_MASK =
        (PID_BITS >= PID_W) ? {PID_W{1'b1}} : PID_W'((1 << PID_BITS) - 1);

    work_t             entry_reg [WQ_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic              push;
    logic [PID_W-1:0]  pid_masked;
    work_t             classified;

    // Classify the incoming command and catch the cases that change nothing.
    always_comb
    begin
        pid_masked        = cmd_data.pid & PID_MASK;
        classified.pid    = pid_masked;
        classified.level  = cmd_data.priority_req;
        classified.status = STAT_OK;
        case (cmd_data.cmd)
            CMD_INSERT:
            begin
                if (cmd_data.priority_req > MAX_PRIORITY ||
                    int'(cmd_data.priority_req) >= LEVELS)
                begin
                    classified.op     = OP_REPORT;
                    classified.status = STAT_BAD_PRIORITY;
                end
                else
                begin
                    classified.op = OP_INSERT;
                end
            end
            CMD_REMOVE:
            begin
                if (pid_masked == '0)
                begin
                    classified.op     = OP_REPORT;
                    classified.status = STAT_REMOVE_ZERO;
                end
                else
                begin
                    classified.op = OP_REMOVE;
                end
            end
            CMD_TIMEOUT:
            begin
                classified.op = OP_TIMEOUT;
            end
            default:
            begin
                classified.op = OP_CLEAR;
            end
        endcase
    end

    // Small command queue so the front keeps taking transfers while the back works.
    assign cmd_stall  = (fill_reg == CNT_W'(WQ_DEPTH));
    assign push       = cmd_valid && !cmd_stall;
    assign work_valid = (fill_reg != '0);
    assign work_head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(WQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (work_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(WQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !work_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && work_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

`default_nettype wire

[rtl/mrrq_back.sv]
`default_nettype none

module mrrq_back
    import mrrq_pkg::*;
#(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int PID_BITS    = PID_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  work_valid,
    output logic       work_pop,
    input  wire work_t work_head,
    output logic       rsp_valid,
    input  wire logic  rsp_stall,
    output rsp_item_t  rsp_data
);

    localparam int LVL_W = $clog2(LEVELS);
    localparam int HW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int AW    = $clog2(LEVELS * QUEUE_DEPTH);

    state_t              state_reg;
    state_t              state_next;
    work_t               cur_reg;
    work_t               cur_next;
    logic [LVL_W-1:0]    lvl_reg;
    logic [LVL_W-1:0]    lvl_next;
    logic [CNT_W-1:0]    k_reg;
    logic [CNT_W-1:0]    k_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [HW-1:0]       heads_reg [LEVELS];
    logic [HW-1:0]       heads_next [LEVELS];
    logic [CNT_W-1:0]    counts_reg [LEVELS];
    logic [CNT_W-1:0]    counts_next [LEVELS];
    logic                out_valid_reg;
    logic                out_valid_next;
    rsp_item_t           out_data_reg;
    rsp_item_t           out_data_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [PID_BITS-1:0] ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [PID_BITS-1:0] ram_rdata;

    logic                top_found;
    logic [LVL_W-1:0]    top_lvl;
    logic                load;
    logic                counts_over;
    logic [23:0]         pid_wide;
    logic [PID_BITS-1:0] pid_st;
    logic [PID_BITS+7:0] rd_wide;
    logic [3:0]          ins_wide;
    logic [LVL_W-1:0]    ins_lvl;

    // Memory address of an offset from the head of a level.
    function automatic logic [AW-1:0] slot_addr(
        input logic [LVL_W-1:0] lv,
        input logic [HW-1:0]    head,
        input logic [CNT_W-1:0] off
    );
        logic [CNT_W:0] pos;
        pos = (CNT_W+1)'(head) + {1'b0, off};
        if (pos >= (CNT_W+1)'(QUEUE_DEPTH))
        begin
            pos = pos - (CNT_W+1)'(QUEUE_DEPTH);
        end
        slot_addr = AW'(lv * QUEUE_DEPTH) + AW'(pos);
    endfunction

    mrrq_ram #(
        .WIDTH (PID_BITS),
        .DEPTH (LEVELS * QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Width conversions of the pid between the channel and the storage.
    assign pid_wide = {16'b0, cur_reg.pid};
    assign pid_st   = pid_wide[PID_BITS-1:0];
    assign rd_wide  = {8'b0, ram_rdata};
    assign ins_wide = {2'b0, cur_reg.level};
    assign ins_lvl  = ins_wide[LVL_W-1:0];

    // Highest non-empty level; the highest index that holds entries wins.
    always_comb
    begin
        top_found = 1'b0;
        top_lvl   = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (counts_reg[i] != '0)
            begin
                top_found = 1'b1;
                top_lvl   = LVL_W'(i);
            end
        end
    end

    assign load      = (state_reg == S_HEAD_OUT) && (!out_valid_reg || !rsp_stall);
    assign work_pop  = (state_reg == S_IDLE) && work_valid;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    // Command sequencer.
    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        lvl_next      = lvl_reg;
        k_next        = k_reg;
        status_next   = status_reg;
        heads_next    = heads_reg;
        counts_next   = counts_reg;
        ram_we        = 1'b0;
        ram_waddr     = slot_addr(lvl_reg, heads_reg[lvl_reg], k_reg);
        ram_wdata     = ram_rdata;
        ram_raddr     = slot_addr(top_lvl, heads_reg[top_lvl], '0);
        out_data_next = out_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (work_valid)
                begin
                    cur_next   = work_head;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next = STAT_OK;
                state_next  = S_HEAD_RD;
                case (cur_reg.op)
                    OP_INSERT:
                    begin
                        if (counts_reg[ins_lvl] >= CNT_W'(QUEUE_DEPTH))
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = slot_addr(ins_lvl, heads_reg[ins_lvl],
                                                  counts_reg[ins_lvl]);
                            ram_wdata = pid_st;
                            counts_next[ins_lvl] = counts_reg[ins_lvl] + 1'b1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        lvl_next   = '0;
                        k_next     = '0;
                        state_next = S_RM_RD;
                    end
                    OP_TIMEOUT:
                    begin
                        if (!top_found)
                        begin
                            status_next = STAT_ALL_EMPTY;
                        end
                        else if (counts_reg[top_lvl] > CNT_W'(1))
                        begin
                            lvl_next   = top_lvl;
                            state_next = S_TO_WR;
                        end
                    end
                    OP_CLEAR:
                    begin
                        for (int i = 0; i < LEVELS; i++)
                        begin
                            heads_next[i]  = '0;
                            counts_next[i] = '0;
                        end
                    end
                    default:
                    begin
                        status_next = cur_reg.status;
                    end
                endcase
            end
            S_RM_RD:
            begin
                // Walk the levels from the lowest; skip a level once it is searched.
                if (k_reg >= counts_reg[lvl_reg])
                begin
                    if (lvl_reg == LVL_W'(LEVELS - 1))
                    begin
                        state_next = S_HEAD_RD;
                    end
                    else
                    begin
                        lvl_next = lvl_reg + 1'b1;
                        k_next   = '0;
                    end
                end
                else
                begin
                    ram_raddr  = slot_addr(lvl_reg, heads_reg[lvl_reg], k_reg);
                    state_next = S_RM_CMP;
                end
            end
            S_RM_CMP:
            begin
                if (ram_rdata == pid_st)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_RM_RD;
                end
            end
            S_SH_RD:
            begin
                // Close the gap: move each later entry one place toward the head.
                if (({1'b0, k_reg} + 1'b1) < {1'b0, counts_reg[lvl_reg]})
                begin
                    ram_raddr  = slot_addr(lvl_reg, heads_reg[lvl_reg], k_reg + 1'b1);
                    state_next = S_SH_WR;
                end
                else
                begin
                    counts_next[lvl_reg] = counts_reg[lvl_reg] - 1'b1;
                    state_next           = S_HEAD_RD;
                end
            end
            S_SH_WR:
            begin
                ram_we     = 1'b1;
                k_next     = k_reg + 1'b1;
                state_next = S_SH_RD;
            end
            S_TO_WR:
            begin
                // The old head goes behind the last entry and the head advances.
                ram_we    = 1'b1;
                ram_waddr = slot_addr(lvl_reg, heads_reg[lvl_reg], counts_reg[lvl_reg]);
                heads_next[lvl_reg] = (heads_reg[lvl_reg] == HW'(QUEUE_DEPTH - 1)) ?
                                      '0 : heads_reg[lvl_reg] + 1'b1;
                state_next = S_HEAD_RD;
            end
            S_HEAD_RD:
            begin
                state_next = S_HEAD_OUT;
            end
            S_HEAD_OUT:
            begin
                if (load)
                begin
                    out_data_next.status        = status_reg;
                    out_data_next.running_pid   = top_found ? rd_wide[7:0] : '0;
                    out_data_next.running_valid = top_found;
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register is freed by a transfer and filled by a new result.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < LEVELS; i++)
            begin
                heads_reg[i]  <= '0;
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            heads_reg     <= heads_next;
            counts_reg    <= counts_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        lvl_reg      <= lvl_next;
        k_reg        <= k_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    // Any level holding more entries than it has room for.
    always_comb
    begin
        counts_over = 1'b0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (counts_reg[i] > CNT_W'(QUEUE_DEPTH))
            begin
                counts_over = 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !counts_over)
        else $error("level count exceeds queue depth");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !(out_valid_reg && rsp_stall))
        else $error("result loaded over a stalled result");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && cur_reg.op == OP_CLEAR) |=> !top_found)
        else $error("clear left a level non-empty");

    a_timeout_ok_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (load && cur_reg.op == OP_TIMEOUT && status_reg == STAT_OK) |-> top_found)
        else $error("successful timeout reported with all levels empty");

endmodule

`default_nettype wire
